// ===== rtl/bpt_pkg.sv =====
// Shared types, constants and helper functions of the breakpoint patch table.
`timescale 1ns / 1ps

package bpt_pkg;

  // Table size and derived widths.
  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths of the transactions.
  localparam int ACT_W  = 2;
  localparam int ADDR_W = 64;
  localparam int WORD_W = 64;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 3;
  localparam int USED_W = 4;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_HIT    = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // Trap patching constants.
  localparam logic [WORD_W-1:0] HIGH_MASK = 64'hFFFF_FFFF_FFFF_FF00;
  localparam logic [WORD_W-1:0] TRAP_OP   = 64'h0000_0000_0000_00CC;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] code_word;
  } bpt_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] original_word;
    logic [WORD_W-1:0] patched_word;
    logic [ADDR_W-1:0] rewound_pc;
    logic [USED_W-1:0] entries_used;
  } bpt_res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
  } bpt_entry_t;

  // Replace the low byte of a code word with the trap opcode.
  function automatic logic [WORD_W-1:0] patch_word(input logic [WORD_W-1:0] w);
    return (w & HIGH_MASK) | TRAP_OP;
  endfunction

endpackage

// ===== rtl/bpt_seq.sv =====
// Sequencer of the breakpoint table: entry storage, shared address comparator and control.
`timescale 1ns / 1ps

module bpt_seq
  import bpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  input  bpt_req_t req,
  output logic     req_ready,
  output logic     res_valid,
  output bpt_res_t res,
  input  logic     res_ready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ADD   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [ACT_W-1:0]  op_r, op_nxt;
  logic [ADDR_W-1:0] key_r, key_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;

  logic [STAT_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [WORD_W-1:0] orig_r, orig_nxt;
  logic [WORD_W-1:0] patched_r, patched_nxt;
  logic [ADDR_W-1:0] rewound_r, rewound_nxt;

  // Table storage with one write port and one registered read port.
  bpt_entry_t mem_r [TABLE_DEPTH];
  bpt_entry_t rd_data_r;
  logic       rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic       we;
  logic [IDX_W-1:0] wr_addr;
  bpt_entry_t wr_data;

  logic issue;
  logic match;

  assign issue = (idx_r < count_r);
  assign match = (rd_data_r.addr == key_r);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    word_nxt    = word_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    status_nxt  = status_r;
    slot_nxt    = slot_r;
    orig_nxt    = orig_r;
    patched_nxt = patched_r;
    rewound_nxt = rewound_r;
    rd_en       = 1'b0;
    rd_addr     = idx_r[IDX_W-1:0];
    we          = 1'b0;
    wr_addr     = cmp_idx_r;
    wr_data     = rd_data_r;
    req_ready   = 1'b0;
    res_valid   = 1'b0;

    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_nxt      = req.action;
          key_nxt     = (req.action == ACT_HIT) ? (req.address - 64'd1) : req.address;
          word_nxt    = req.code_word;
          idx_nxt     = '0;
          status_nxt  = STAT_MISS;
          slot_nxt    = '0;
          orig_nxt    = '0;
          patched_nxt = '0;
          rewound_nxt = '0;
          case (req.action)
            ACT_ADD:    state_nxt = S_ADD;
            ACT_REMOVE: state_nxt = S_SCAN;
            ACT_HIT:    state_nxt = S_SCAN;
            default:    state_nxt = S_DONE;
          endcase
        end
      end

      S_ADD: begin
        if (count_r == CNT_W'(TABLE_DEPTH)) begin
          status_nxt = STAT_FULL;
        end else begin
          we          = 1'b1;
          wr_addr     = IDX_W'(count_r);
          wr_data     = '{addr: key_r, word: word_r};
          count_nxt   = count_r + CNT_W'(1);
          status_nxt  = STAT_DONE;
          slot_nxt    = IDX_W'(count_r);
          orig_nxt    = word_r;
          patched_nxt = patch_word(word_r);
        end
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        if (cmp_vld_r && match) begin
          status_nxt = STAT_DONE;
          slot_nxt   = cmp_idx_r;
          orig_nxt   = rd_data_r.word;
          if (op_r == ACT_HIT) begin
            patched_nxt = patch_word(rd_data_r.word);
            rewound_nxt = key_r;
            state_nxt   = S_DONE;
          end else begin
            idx_nxt   = CNT_W'(cmp_idx_r) + CNT_W'(1);
            state_nxt = S_SHIFT;
          end
        end else if (issue) begin
          rd_en       = 1'b1;
          idx_nxt     = idx_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[IDX_W-1:0];
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SHIFT: begin
        // Each entry read here lands one place lower on the following cycle.
        if (cmp_vld_r) begin
          we = 1'b1;
        end
        if (issue) begin
          rd_en       = 1'b1;
          idx_nxt     = idx_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = IDX_W'(idx_r - CNT_W'(1));
        end else if (!cmp_vld_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    word_r    <= word_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
    orig_r    <= orig_nxt;
    patched_r <= patched_nxt;
    rewound_r <= rewound_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign res.status        = status_r;
  assign res.slot          = SLOT_W'(slot_r);
  assign res.original_word = orig_r;
  assign res.patched_word  = patched_r;
  assign res.rewound_pc    = rewound_r;
  assign res.entries_used  = USED_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_count_source: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ($past(state_r) == S_ADD || $past(state_r) == S_SHIFT))
    else $error("entry count changed outside add or shift");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !we)
    else $error("table written while no item is in work");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result changed while waiting for the output register");

endmodule

// ===== rtl/breakpoint_patch_table_core.sv =====
// Top level of the breakpoint patch table: stream ports, sequencer and output register.
`timescale 1ns / 1ps

// The block keeps an ordered table of up to TABLE_DEPTH (8) software breakpoints,
// each an address and the original code word found there, and answers every
// input transaction with exactly one result transaction. An add appends an
// entry and returns the word with its low byte replaced by the trap opcode 0xCC;
// a full table answers with status 2 and leaves the table alone. A remove finds
// the first entry with a matching address, returns its saved word and closes the
// gap by moving the later entries down. A hit check looks up the trapped pc
// minus one and returns the rewound pc, the saved word and the re-patch word.
// Duplicate adds are kept; remove and hit check use the first match. Items are
// handled one at a time: the table has one read port and one 64-bit address
// comparator, and the scan and the compaction walk the entries one per cycle.
// An add goes through the add state and the done state before its result enters
// the output register; a hit check or an unmatched remove first compares the
// entries in order, and a matched remove then compacts the table, moving each
// later entry down one slot. A finished result waits in the output register,
// so the next transaction is taken while it is pending.
// After reset the table is empty; no clearing pass is needed.

module breakpoint_patch_table_core
  import bpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // address [63:0], code_word [127:64]
  input  logic [1:0]   in_tuser,   // action [1:0]

  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,  // slot [2:0], original_word [66:3], patched_word [130:67],
                                   // rewound_pc [194:131], entries_used [198:195], zero [199]
  output logic [1:0]   out_tuser   // status [1:0]
);

  bpt_req_t req;
  bpt_res_t res;
  logic     res_valid;
  logic     res_ready;

  logic     out_valid_r;
  bpt_res_t out_res_r;

  // Unpack the input transaction.
  assign req.action    = in_tuser;
  assign req.address   = in_tdata[63:0];
  assign req.code_word = in_tdata[127:64];

  bpt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0,
                       out_res_r.entries_used,
                       out_res_r.rewound_pc,
                       out_res_r.patched_word,
                       out_res_r.original_word,
                       out_res_r.slot};

endmodule
